// ----- rtl/subtitle_pixel_run_decoder_defines.svh -----
// Assertion macros used by the RTL of the subtitle pixel run decoder.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SUBTITLE_PIXEL_RUN_DECODER_DEFINES_SVH
`define SUBTITLE_PIXEL_RUN_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPR_ASSERT_SAME(lbl, ante, cons, msg)

`define SPR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/spr_pkg.sv -----
`default_nettype none

package spr_pkg;

    localparam int BUF_W      = 24;
    localparam int HELD_W     = 5;
    localparam int CODE_W     = 8;
    localparam int LEN_W      = 9;
    localparam int CNT_W      = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;
    localparam int MODE_W     = 2;
    localparam int RUN_CNT_W  = 2;

    localparam logic [MODE_W-1:0] MODE_TWO_BIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FOUR_BIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EIGHT_BIT = 2'd2;

    // Index of the last decode allowed per input item before the item is closed.
    localparam logic [RUN_CNT_W-1:0] LAST_RUN_IDX = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // One code as seen by the decode unit.
    typedef struct packed {
        logic              ok;
        logic [HELD_W-1:0] used;
        logic [CODE_W-1:0] pixel_code;
        logic [LEN_W-1:0]  run_length;
        logic              string_end;
    } code_res_t;

    // One result item as it travels to the output register.
    typedef struct packed {
        logic [CNT_W-1:0]  pixels_total;
        logic [CNT_W-1:0]  bytes_used;
        logic [LEN_W-1:0]  run_length;
        logic [CODE_W-1:0] pixel_code;
        logic              string_end;
    } run_t;

endpackage

`default_nettype wire

// ----- rtl/spr_code_unit.sv -----
`default_nettype none

module spr_code_unit (
    input  wire logic [spr_pkg::MODE_W-1:0] mode,
    input  wire logic [spr_pkg::BUF_W-1:0]  bit_buf,
    input  wire logic [spr_pkg::HELD_W-1:0] bits_held,
    output spr_pkg::code_res_t              res
);
    import spr_pkg::*;

    logic [HELD_W-1:0] shamt;
    logic [BUF_W-1:0]  a;

    // Left-align the held bits so the next code always starts at bit 23.
    assign shamt = HELD_W'(BUF_W) - bits_held;
    assign a     = bit_buf << shamt;

    always_comb
    begin
        res = '0;
        unique case (mode)
            MODE_TWO_BIT:
            begin
                if (bits_held >= 5'd2 && a[23:22] != 2'd0)
                begin
                    res = '{1'b1, 5'd2, 8'(a[23:22]), 9'd1, 1'b0};
                end
                else if (bits_held >= 5'd3 && a[21])
                begin
                    if (bits_held >= 5'd8)
                    begin
                        res = '{1'b1, 5'd8, 8'(a[17:16]), 9'(a[20:18]) + 9'd3, 1'b0};
                    end
                end
                else if (bits_held >= 5'd4 && a[20])
                begin
                    res = '{1'b1, 5'd4, 8'd0, 9'd1, 1'b0};
                end
                else if (bits_held >= 5'd6)
                begin
                    unique case (a[19:18])
                        2'd0: res = '{1'b1, 5'd6, 8'd0, 9'd0, 1'b1};
                        2'd1: res = '{1'b1, 5'd6, 8'd0, 9'd2, 1'b0};
                        2'd2:
                        begin
                            if (bits_held >= 5'd12)
                            begin
                                res = '{1'b1, 5'd12, 8'(a[13:12]),
                                        9'(a[17:14]) + 9'd12, 1'b0};
                            end
                        end
                        default:
                        begin
                            if (bits_held >= 5'd16)
                            begin
                                res = '{1'b1, 5'd16, 8'(a[9:8]),
                                        9'(a[17:10]) + 9'd29, 1'b0};
                            end
                        end
                    endcase
                end
            end
            MODE_FOUR_BIT:
            begin
                if (bits_held >= 5'd4 && a[23:20] != 4'd0)
                begin
                    res = '{1'b1, 5'd4, 8'(a[23:20]), 9'd1, 1'b0};
                end
                else if (bits_held >= 5'd5 && !a[19])
                begin
                    if (bits_held >= 5'd8)
                    begin
                        if (a[18:16] == 3'd0)
                            res = '{1'b1, 5'd8, 8'd0, 9'd0, 1'b1};
                        else
                            res = '{1'b1, 5'd8, 8'd0, 9'(a[18:16]) + 9'd2, 1'b0};
                    end
                end
                else if (bits_held >= 5'd6 && !a[18])
                begin
                    if (bits_held >= 5'd12)
                    begin
                        res = '{1'b1, 5'd12, 8'(a[15:12]), 9'(a[17:16]) + 9'd4, 1'b0};
                    end
                end
                else if (bits_held >= 5'd8)
                begin
                    unique case (a[17:16])
                        2'd0: res = '{1'b1, 5'd8, 8'd0, 9'd1, 1'b0};
                        2'd1: res = '{1'b1, 5'd8, 8'd0, 9'd2, 1'b0};
                        2'd2:
                        begin
                            if (bits_held >= 5'd16)
                            begin
                                res = '{1'b1, 5'd16, 8'(a[11:8]),
                                        9'(a[15:12]) + 9'd9, 1'b0};
                            end
                        end
                        default:
                        begin
                            if (bits_held >= 5'd20)
                            begin
                                res = '{1'b1, 5'd20, 8'(a[7:4]),
                                        9'(a[15:8]) + 9'd25, 1'b0};
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                // The unused mode code decodes as eight-bit codes.
                if (bits_held >= 5'd8 && a[23:16] != 8'd0)
                begin
                    res = '{1'b1, 5'd8, a[23:16], 9'd1, 1'b0};
                end
                else if (bits_held >= 5'd16 && !a[15])
                begin
                    if (a[14:8] == 7'd0)
                        res = '{1'b1, 5'd16, 8'd0, 9'd0, 1'b1};
                    else
                        res = '{1'b1, 5'd16, 8'd0, 9'(a[14:8]), 1'b0};
                end
                else if (bits_held >= 5'd24)
                begin
                    res = '{1'b1, 5'd24, a[7:0], 9'(a[14:8]), 1'b0};
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/subtitle_pixel_run_decoder.sv -----
// An accepted byte moves the state machine from ST_IDLE to ST_DECODE, which decodes
// one code per cycle while the output is not stalled, up to four codes or the end code.
// Each result waits in a hold register until the next code or ST_FLUSH shows whether it
// is the last of the byte, then moves to the output register; new bytes enter in ST_IDLE only.
// A byte that is ignored while no string is open leaves the decoder in ST_IDLE.
// Reset (rst_n, asynchronous, active low) selects four-bit coding and empties the buffer.
`default_nettype none

`include "subtitle_pixel_run_decoder_defines.svh"

module subtitle_pixel_run_decoder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [spr_pkg::MODE_W-1:0]         cfg_wr_data,   // coding_mode
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [spr_pkg::IN_DATA_W-1:0]      s_tdata,       // code_byte
    input  wire logic                               s_tuser,       // string_start
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: pixel_code, run_length, bytes_used, pixels_total, zero padding
    output logic [spr_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                    m_tuser,       // string_end
    output logic                                    m_tlast        // last_of_byte
);
    import spr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_FLUSH  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [MODE_W-1:0]      mode_reg;
    logic [BUF_W-1:0]       buf_reg, buf_next;
    logic [HELD_W-1:0]      bits_held_reg, bits_held_next;
    logic [CNT_W-1:0]       byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]       pixel_count_reg, pixel_count_next;
    logic                   string_done_reg, string_done_next;
    logic [RUN_CNT_W-1:0]   run_cnt_reg, run_cnt_next;
    run_t                   hold_reg, hold_next;
    logic                   hold_valid_reg, hold_valid_next;
    run_t                   out_reg, out_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_valid_reg, out_valid_next;

    code_res_t              dec;
    logic                   can_push;
    logic [CNT_W:0]         pix_sum;
    logic [HELD_W-1:0]      held_left;
    logic [HELD_W:0]        held_add;
    logic [BUF_W-1:0]       keep_mask;

    spr_code_unit u_code (
        .mode      (mode_reg),
        .bit_buf   (buf_reg),
        .bits_held (bits_held_reg),
        .res       (dec)
    );

    assign can_push  = !out_valid_reg || m_tready;
    assign pix_sum   = {1'b0, pixel_count_reg} + (CNT_W+1)'(dec.run_length);
    assign held_left = bits_held_reg - dec.used;
    assign held_add  = {1'b0, bits_held_reg} + (HELD_W+1)'(8);
    assign keep_mask = ~({BUF_W{1'b1}} << held_left);

    always_comb
    begin
        state_next       = state_reg;
        buf_next         = buf_reg;
        bits_held_next   = bits_held_reg;
        byte_count_next  = byte_count_reg;
        pixel_count_next = pixel_count_reg;
        string_done_next = string_done_reg;
        run_cnt_next     = run_cnt_reg;
        hold_next        = hold_reg;
        hold_valid_next  = hold_valid_reg;
        out_next         = out_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (s_tuser || !string_done_reg))
                begin
                    run_cnt_next     = '0;
                    string_done_next = 1'b0;
                    state_next       = ST_DECODE;
                    if (s_tuser)
                    begin
                        buf_next         = BUF_W'(s_tdata);
                        bits_held_next   = HELD_W'(8);
                        byte_count_next  = CNT_W'(1);
                        pixel_count_next = '0;
                    end
                    else
                    begin
                        buf_next       = {buf_reg[BUF_W-IN_DATA_W-1:0], s_tdata};
                        bits_held_next = (held_add > (HELD_W+1)'(BUF_W)) ?
                                         HELD_W'(BUF_W) : held_add[HELD_W-1:0];
                        if (byte_count_reg != CNT_MAX)
                            byte_count_next = byte_count_reg + CNT_W'(1);
                    end
                end
            end
            ST_DECODE:
            begin
                if (!dec.ok)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!hold_valid_reg || can_push)
                begin
                    // The held result is known not to be the last one of the item.
                    if (hold_valid_reg)
                    begin
                        out_next       = hold_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    pixel_count_next = pix_sum[CNT_W] ? CNT_MAX : pix_sum[CNT_W-1:0];
                    hold_valid_next  = 1'b1;
                    hold_next.pixel_code   = dec.pixel_code;
                    hold_next.run_length   = dec.run_length;
                    hold_next.string_end   = dec.string_end;
                    hold_next.bytes_used   = dec.string_end ? byte_count_reg : '0;
                    hold_next.pixels_total = dec.string_end ? pixel_count_next : '0;
                    run_cnt_next = run_cnt_reg + RUN_CNT_W'(1);
                    if (dec.string_end)
                    begin
                        buf_next         = '0;
                        bits_held_next   = '0;
                        string_done_next = 1'b1;
                        state_next       = ST_FLUSH;
                    end
                    else
                    begin
                        buf_next       = buf_reg & keep_mask;
                        bits_held_next = held_left;
                        if (run_cnt_reg == LAST_RUN_IDX)
                            state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_push)
                begin
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A mode write drops any string that is open.
        if (cfg_wr_en)
        begin
            buf_next         = '0;
            bits_held_next   = '0;
            string_done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_FOUR_BIT;
            buf_reg         <= '0;
            bits_held_reg   <= '0;
            byte_count_reg  <= '0;
            pixel_count_reg <= '0;
            string_done_reg <= 1'b1;
            run_cnt_reg     <= '0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_wr_en)
                mode_reg    <= cfg_wr_data;
            buf_reg         <= buf_next;
            bits_held_reg   <= bits_held_next;
            byte_count_reg  <= byte_count_next;
            pixel_count_reg <= pixel_count_next;
            string_done_reg <= string_done_next;
            run_cnt_reg     <= run_cnt_next;
            hold_valid_reg  <= hold_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.string_end;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_reg.pixels_total, out_reg.bytes_used,
                       out_reg.run_length, out_reg.pixel_code};

    `SPR_ASSERT_SAME(a_idle_no_hold, s_tready, !hold_valid_reg, "held result left in idle")
    `SPR_ASSERT_SAME(a_held_range, 1'b1, bits_held_reg <= HELD_W'(BUF_W), "accumulator overfull")
    `SPR_ASSERT_SAME(a_end_is_last, m_tvalid && m_tuser, m_tlast, "end result not last of byte")
    `SPR_ASSERT_NEXT(a_end_closes,
        state_reg == ST_DECODE && dec.ok && dec.string_end && (!hold_valid_reg || can_push),
        string_done_reg && bits_held_reg == '0, "end code did not close the string")

endmodule

`default_nettype wire

// ----- bench/tb_subtitle_pixel_run_decoder.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0]  pixel_code;
    logic [8:0]  run_length;
    logic        string_end;
    logic        last_of_byte;
    logic [15:0] bytes_used;
    logic [15:0] pixels_total;
} pixel_run_t;

class pixel_run_scoreboard;
    logic [1:0]  coding_mode;
    int unsigned acc;
    int unsigned held;
    int unsigned byte_count;
    int unsigned pixel_count;
    bit          string_done;
    pixel_run_t  expected_runs[$];
    int unsigned errors;

    function new();
        coding_mode = spr_pkg::MODE_FOUR_BIT;
        acc = 0;
        held = 0;
        byte_count = 0;
        pixel_count = 0;
        string_done = 1'b1;
        errors = 0;
    endfunction

    // A mode write drops any open string; the new mode applies from the next start.
    function void set_mode(logic [1:0] m);
        coding_mode = m;
        acc = 0;
        held = 0;
        string_done = 1'b1;
    endfunction

    function int unsigned peek(int unsigned n);
        return (acc >> (held - n)) & ((32'd1 << n) - 32'd1);
    endfunction

    function int unsigned decode_two(output int unsigned code, len, output bit fin);
        int unsigned v;
        int unsigned s;
        code = 0;
        len = 0;
        fin = 1'b0;
        if (held < 2) return 0;
        v = peek(2);
        if (v != 0)
        begin
            code = v;
            len = 1;
            return 2;
        end
        if (held < 3) return 0;
        if ((peek(3) & 1) != 0)
        begin
            if (held < 8) return 0;
            v = peek(8);
            code = v & 3;
            len = ((v >> 2) & 7) + 3;
            return 8;
        end
        if (held < 4) return 0;
        if ((peek(4) & 1) != 0)
        begin
            len = 1;
            return 4;
        end
        if (held < 6) return 0;
        s = peek(6) & 3;
        if (s == 0)
        begin
            fin = 1'b1;
            return 6;
        end
        if (s == 1)
        begin
            len = 2;
            return 6;
        end
        if (s == 2)
        begin
            if (held < 12) return 0;
            v = peek(12);
            code = v & 3;
            len = ((v >> 2) & 15) + 12;
            return 12;
        end
        if (held < 16) return 0;
        v = peek(16);
        code = v & 3;
        len = ((v >> 2) & 255) + 29;
        return 16;
    endfunction

    function int unsigned decode_four(output int unsigned code, len, output bit fin);
        int unsigned v;
        int unsigned s;
        code = 0;
        len = 0;
        fin = 1'b0;
        if (held < 4) return 0;
        v = peek(4);
        if (v != 0)
        begin
            code = v;
            len = 1;
            return 4;
        end
        if (held < 5) return 0;
        if ((peek(5) & 1) == 0)
        begin
            if (held < 8) return 0;
            v = peek(8) & 7;
            if (v == 0)
                fin = 1'b1;
            else
                len = v + 2;
            return 8;
        end
        if (held < 6) return 0;
        if ((peek(6) & 1) == 0)
        begin
            if (held < 12) return 0;
            v = peek(12);
            code = v & 15;
            len = ((v >> 4) & 3) + 4;
            return 12;
        end
        if (held < 8) return 0;
        s = peek(8) & 3;
        if (s == 0)
        begin
            len = 1;
            return 8;
        end
        if (s == 1)
        begin
            len = 2;
            return 8;
        end
        if (s == 2)
        begin
            if (held < 16) return 0;
            v = peek(16);
            code = v & 15;
            len = ((v >> 4) & 15) + 9;
            return 16;
        end
        if (held < 20) return 0;
        v = peek(20);
        code = v & 15;
        len = ((v >> 4) & 255) + 25;
        return 20;
    endfunction

    function int unsigned decode_eight(output int unsigned code, len, output bit fin);
        int unsigned v;
        code = 0;
        len = 0;
        fin = 1'b0;
        if (held < 8) return 0;
        v = peek(8);
        if (v != 0)
        begin
            code = v;
            len = 1;
            return 8;
        end
        if (held < 16) return 0;
        v = peek(16);
        if ((v & 32'h80) == 0)
        begin
            if ((v & 127) == 0)
                fin = 1'b1;
            else
                len = v & 127;
            return 16;
        end
        if (held < 24) return 0;
        v = peek(24);
        code = v & 255;
        len = (v >> 8) & 127;
        return 24;
    endfunction

    // Returns 1 when the byte was taken into a string, 0 when it was ignored.
    function bit note_byte(logic [7:0] cb, logic st);
        pixel_run_t  runs [4];
        int unsigned used;
        int unsigned code;
        int unsigned len;
        int unsigned count;
        bit          fin;
        if (st)
        begin
            acc = 0;
            held = 0;
            byte_count = 0;
            pixel_count = 0;
            string_done = 1'b0;
        end
        else if (string_done)
            return 1'b0;

        if (byte_count < 65535) byte_count++;
        acc = ((acc << 8) | cb) & 32'hFF_FFFF;
        held += 8;
        if (held > 24) held = 24;

        count = 0;
        while (count < 4)
        begin
            case (coding_mode)
                spr_pkg::MODE_TWO_BIT:  used = decode_two(code, len, fin);
                spr_pkg::MODE_FOUR_BIT: used = decode_four(code, len, fin);
                default:                used = decode_eight(code, len, fin);
            endcase
            if (used == 0 || used > held) break;
            held -= used;
            acc &= (32'd1 << held) - 32'd1;
            pixel_count += len;
            if (pixel_count > 65535) pixel_count = 65535;
            runs[count].pixel_code   = code[7:0];
            runs[count].run_length   = len[8:0];
            runs[count].string_end   = fin;
            runs[count].last_of_byte = 1'b0;
            runs[count].bytes_used   = fin ? byte_count[15:0] : 16'd0;
            runs[count].pixels_total = fin ? pixel_count[15:0] : 16'd0;
            count++;
            if (fin)
            begin
                string_done = 1'b1;
                acc = 0;
                held = 0;
                break;
            end
        end
        if (count > 0) runs[count - 1].last_of_byte = 1'b1;
        for (int i = 0; i < count; i++) expected_runs.push_back(runs[i]);
        return 1'b1;
    endfunction

    function void compare_field(string field, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
        end
    endfunction

    function void check_run(logic [spr_pkg::OUT_DATA_W-1:0] data, logic user, logic lst);
        pixel_run_t want;
        if (expected_runs.size() == 0)
        begin
            errors++;
            $error("run with nothing expected: pixel_code %0d, run_length %0d",
                   data[7:0], data[16:8]);
            return;
        end
        want = expected_runs.pop_front();
        compare_field("pixel_code", want.pixel_code, data[7:0]);
        compare_field("run_length", want.run_length, data[16:8]);
        compare_field("string_end", want.string_end, user);
        compare_field("last_of_byte", want.last_of_byte, lst);
        compare_field("bytes_used", want.bytes_used, data[32:17]);
        compare_field("pixels_total", want.pixels_total, data[48:33]);
    endfunction
endclass

module tb_subtitle_pixel_run_decoder;

    localparam logic [spr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [spr_pkg::MODE_W-1:0]      cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [spr_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [spr_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    pixel_run_scoreboard sb;
    bit          code_bits[$];
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    int          items_decoded = 0;
    bit          hold_request = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int unsigned rx_cycle = 0;

    logic [spr_pkg::MODE_W-1:0] phase_modes [0:6] = '{spr_pkg::MODE_TWO_BIT,
        spr_pkg::MODE_EIGHT_BIT, spr_pkg::MODE_FOUR_BIT, MODE_UNUSED,
        spr_pkg::MODE_TWO_BIT, spr_pkg::MODE_FOUR_BIT, spr_pkg::MODE_EIGHT_BIT};

    subtitle_pixel_run_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("tb_subtitle_pixel_run_decoder: done, errors");
        $finish;
    end

    // Output side: check every accepted run, then pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_run(m_tdata, m_tuser, m_tlast);
            rx_cycle++;
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 128) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((rx_cycle % 5) < 3);
                endcase
            end
        end
    end

    task automatic append_field(input int unsigned v, input int unsigned n);
        for (int i = int'(n); i > 0; i--) code_bits.push_back(1'((v >> (i - 1)) & 1));
    endtask

    task automatic build_random_string(input logic [1:0] m, input int n, input bit with_end);
        int kind;
        code_bits.delete();
        repeat (n)
        begin
            case (m)
                spr_pkg::MODE_TWO_BIT:
                begin
                    kind = $urandom_range(0, 5);
                    case (kind)
                        0: append_field($urandom_range(1, 3), 2);
                        1: append_field(32'h20 | $urandom_range(0, 31), 8);
                        2: append_field(1, 4);
                        3: append_field(1, 6);
                        4: append_field(32'h080 | $urandom_range(0, 63), 12);
                        default: append_field(32'hC00 | $urandom_range(0, 1023), 16);
                    endcase
                end
                spr_pkg::MODE_FOUR_BIT:
                begin
                    kind = $urandom_range(0, 6);
                    case (kind)
                        0: append_field($urandom_range(1, 15), 4);
                        1: append_field($urandom_range(1, 7), 8);
                        2: append_field(32'h080 | $urandom_range(0, 63), 12);
                        3: append_field(8'h0C, 8);
                        4: append_field(8'h0D, 8);
                        5: append_field(32'h0E00 | $urandom_range(0, 255), 16);
                        default: append_field(32'hF000 | $urandom_range(0, 4095), 20);
                    endcase
                end
                default:
                begin
                    kind = $urandom_range(0, 2);
                    case (kind)
                        0: append_field($urandom_range(1, 255), 8);
                        1: append_field($urandom_range(1, 127), 16);
                        default: append_field(32'h8000 | $urandom_range(0, 32767), 24);
                    endcase
                end
            endcase
        end
        if (with_end)
        begin
            case (m)
                spr_pkg::MODE_TWO_BIT:  append_field(0, 6);
                spr_pkg::MODE_FOUR_BIT: append_field(0, 8);
                default:                append_field(0, 16);
            endcase
        end
    endtask

    task automatic send_item(input logic [7:0] cb, input logic st);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tdata <= cb;
        s_tuser <= st;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (sb.note_byte(cb, st)) items_decoded++;
    endtask

    // Pads the gathered bits with random ones up to a whole byte and sends them.
    task automatic send_coded_string();
        logic [7:0] cb;
        while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(0, 1)));
        for (int i = 0; i < code_bits.size() / 8; i++)
        begin
            for (int k = 0; k < 8; k++) cb[7 - k] = code_bits[i * 8 + k];
            send_item(cb, i == 0);
        end
    endtask

    task automatic write_mode(input logic [1:0] m);
        s_tvalid <= 1'b0;
        while (sb.expected_runs.size() != 0) @(posedge clk);
        // A byte that completes no code may still be in the decoder.
        repeat (10) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_mode(m);
        burst_left = 0;
    endtask

    initial
    begin
        int pick;
        int phase_start;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Four-bit coding from reset: single pixel, longest run, three-bit run, end.
        code_bits.delete();
        append_field(4'hF, 4);
        append_field(8'h0F, 8);
        append_field(8'hFF, 8);
        append_field(4'hF, 4);
        append_field(8'h07, 8);
        append_field(0, 8);
        send_coded_string();

        // No string is open, so these bytes are ignored.
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);

        // A start in the middle of a string drops what was pending.
        send_item(8'h12, 1'b1);
        send_item(8'h30, 1'b0);
        send_item(8'hAB, 1'b1);
        send_item(8'h00, 1'b0);

        // A mode write aborts the open string; the next byte has no string.
        send_item(8'h10, 1'b1);
        write_mode(spr_pkg::MODE_TWO_BIT);
        send_item(8'h55, 1'b0);

        code_bits.delete();
        append_field(6'b000011, 6);
        append_field(10'h3FF, 10);
        append_field(1, 2);
        append_field(2, 2);
        append_field(3, 2);
        append_field(0, 6);
        send_coded_string();

        // Eight-bit coding, including a coded run of zero pixels.
        write_mode(spr_pkg::MODE_EIGHT_BIT);
        code_bits.delete();
        append_field(8'hFF, 8);
        append_field(1, 9);
        append_field(0, 7);
        append_field(8'hFF, 8);
        append_field(0, 16);
        send_coded_string();

        // The unused mode value decodes eight-bit codes.
        write_mode(MODE_UNUSED);
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b0);

        for (int ph = 0; ph < 7; ph++)
        begin
            write_mode(phase_modes[ph]);
            hold_request = (ph == 2);
            no_gaps = (ph == 4);
            phase_start = items_decoded;
            while (items_decoded - phase_start < 50)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    build_random_string(phase_modes[ph], $urandom_range(1, 10), 1'b1);
                    send_coded_string();
                end
                else if (pick == 7)
                begin
                    build_random_string(phase_modes[ph], $urandom_range(1, 6), 1'b0);
                    send_coded_string();
                end
                else if (pick == 8)
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
                else
                begin
                    build_random_string(phase_modes[ph], $urandom_range(0, 1) * 20, 1'b1);
                    send_coded_string();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.expected_runs.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_subtitle_pixel_run_decoder: done, clean");
        else
            $display("tb_subtitle_pixel_run_decoder: done, errors");
        $finish;
    end

endmodule
